/* rtl/ofrq_pkg.sv */
package ofrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int FRAME_BYTES_DEF = 64;

  localparam int BYTE_W        = 8;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int FRAME_COUNT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_PULL  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NORMAL   = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    flush;
    logic    meta_rd;
    logic    pop;
    logic    byte_rd;
    logic    out_load;
    logic    out_stream;
    logic    out_last;
    status_t out_status;
  } ofrq_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic meta_ovf;
    logic len_zero;
    logic issue_more;
    logic issue_last;
  } ofrq_stat_t;

endpackage

/* rtl/ofrq_if.sv */
interface ofrq_cmd_if import ofrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  logic              discard_frame;

  modport source (
    output valid, command, data_byte, last_byte, discard_frame,
    input  ready
  );
  modport sink (
    input  valid, command, data_byte, last_byte, discard_frame,
    output ready
  );
endinterface

interface ofrq_res_if import ofrq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status_code;
  logic                     byte_valid;
  logic [BYTE_W-1:0]        out_byte;
  logic                     out_last;
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic                     queue_empty;
  logic                     queue_full;

  modport source (
    output valid, status_code, byte_valid, out_byte, out_last, frame_count,
           queue_empty, queue_full,
    input  ready
  );
  modport sink (
    input  valid, status_code, byte_valid, out_byte, out_last, frame_count,
           queue_empty, queue_full,
    output ready
  );
endinterface

/* rtl/ofrq_datapath.sv */
module ofrq_datapath import ofrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ofrq_ctl_t                ctl,
  input  logic [BYTE_W-1:0]        data_byte,
  input  logic                     last_byte,
  output ofrq_stat_t               stat,
  output logic [STATUS_W-1:0]      status_code,
  output logic                     byte_valid,
  output logic [BYTE_W-1:0]        out_byte,
  output logic                     out_last,
  output logic [FRAME_COUNT_W-1:0] frame_count,
  output logic                     queue_empty,
  output logic                     queue_full
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int OFF_W  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int ADDR_W = $clog2(QUEUE_DEPTH * FRAME_BYTES);
  localparam int WIDE_W = (IDX_W + 1 > FRAME_COUNT_W) ? IDX_W + 1 : FRAME_COUNT_W;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] slot,
                                                  input logic [OFF_W-1:0] off);
    return ADDR_W'(slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(off);
  endfunction

  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [LEN_W-1:0]  push_cnt, push_cnt_next;
  logic              push_ovf, push_ovf_next;
  logic              room;
  logic [LEN_W-1:0]  cnt_after;
  logic              ovf_after;

  logic [BYTE_W-1:0] byte_mem [QUEUE_DEPTH * FRAME_BYTES];
  logic [LEN_W:0]    meta_mem [QUEUE_DEPTH];
  logic [LEN_W:0]    meta_q;
  logic [BYTE_W-1:0] rdata;
  logic [IDX_W-1:0]  rd_slot;
  logic [LEN_W-1:0]  rd_off;
  logic [LEN_W-1:0]  len_q;

  logic [WIDE_W-1:0] h_w, t_w, diff_w;

  assign room      = push_cnt < LEN_W'(FRAME_BYTES);
  assign cnt_after = room ? push_cnt + 1'b1 : push_cnt;
  assign ovf_after = room ? push_ovf : 1'b1;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    push_cnt_next = push_cnt;
    push_ovf_next = push_ovf;
    if (ctl.push) begin
      if (last_byte) begin
        head_next     = adv(head);
        tail_next     = (adv(head) == tail) ? adv(tail) : tail;
        push_cnt_next = '0;
        push_ovf_next = 1'b0;
      end else begin
        push_cnt_next = cnt_after;
        push_ovf_next = ovf_after;
      end
    end
    if (ctl.flush) begin
      head_next     = '0;
      tail_next     = '0;
      push_cnt_next = '0;
      push_ovf_next = 1'b0;
    end
    if (ctl.pop) begin
      tail_next = adv(tail);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      push_cnt <= '0;
      push_ovf <= 1'b0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      push_cnt <= push_cnt_next;
      push_ovf <= push_ovf_next;
    end
  end

  // Byte store: one write port for pushes, one registered read for pulls.
  always_ff @(posedge clk) begin
    if (ctl.push && room) begin
      byte_mem[slot_addr(head, push_cnt[OFF_W-1:0])] <= data_byte;
    end
    if (ctl.byte_rd) begin
      rdata <= byte_mem[slot_addr(rd_slot, rd_off[OFF_W-1:0])];
    end
  end

  // Per-slot length and oversize mark, written on commit.
  always_ff @(posedge clk) begin
    if (ctl.push && last_byte) begin
      meta_mem[head] <= {ovf_after, cnt_after};
    end
    if (ctl.meta_rd) begin
      meta_q <= meta_mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.meta_rd) begin
      rd_slot <= tail;
    end
    if (ctl.pop) begin
      rd_off <= '0;
    end else if (ctl.byte_rd) begin
      rd_off <= rd_off + 1'b1;
    end
  end

  assign len_q           = meta_q[LEN_W-1:0];
  assign stat.empty      = head == tail;
  assign stat.meta_ovf   = meta_q[LEN_W];
  assign stat.len_zero   = len_q == '0;
  assign stat.issue_more = rd_off != len_q;
  assign stat.issue_last = (rd_off + 1'b1) == len_q;

  assign h_w    = WIDE_W'(head_next);
  assign t_w    = WIDE_W'(tail_next);
  assign diff_w = (h_w >= t_w) ? h_w - t_w : h_w + WIDE_W'(QUEUE_DEPTH) - t_w;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status_code <= ctl.out_status;
      byte_valid  <= ctl.out_stream;
      out_byte    <= ctl.out_stream ? rdata : '0;
      out_last    <= ctl.out_stream ? ctl.out_last : 1'b1;
      frame_count <= diff_w[FRAME_COUNT_W-1:0];
      queue_empty <= head_next == tail_next;
      queue_full  <= adv(head_next) == tail_next;
    end
  end

  a_commit_not_empty: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && last_byte) |=> (head != tail))
    else $error("ring empty after a frame was committed");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (head != tail))
    else $error("slot freed from an empty ring");

endmodule

/* rtl/ofrq_ctrl.sv */
module ofrq_ctrl import ofrq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  logic [CMD_W-1:0] command,
  input  logic             discard_frame,
  output logic             res_valid,
  input  logic             res_ready,
  input  ofrq_stat_t       stat,
  output ofrq_ctl_t        ctl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_META   = 4'b0010,
    S_STREAM = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t  state, state_next;
  status_t emit_code, emit_code_next;
  status_t res_code;
  logic    want_res;
  logic    discard_q;
  logic    pend, pend_last;
  logic    slot_free;
  logic    consume;

  assign cmd_ready = state == S_IDLE;
  assign slot_free = !res_valid || res_ready;
  assign consume   = (state == S_STREAM) && pend && slot_free;

  always_comb begin
    ctl            = '0;
    state_next     = state;
    emit_code_next = emit_code;
    want_res       = 1'b0;
    res_code       = ST_NORMAL;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_code_t'(command))
            CMD_PUSH: begin
              ctl.push = 1'b1;
              want_res = 1'b1;
            end
            CMD_FLUSH: begin
              ctl.flush = 1'b1;
              want_res  = 1'b1;
            end
            CMD_QUERY: begin
              want_res = 1'b1;
            end
            CMD_PULL: begin
              if (stat.empty) begin
                want_res = 1'b1;
                res_code = ST_EMPTY;
              end else begin
                ctl.meta_rd = 1'b1;
                state_next  = S_META;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_META: begin
        if (stat.meta_ovf) begin
          want_res = 1'b1;
          res_code = ST_OVERSIZE;
        end else begin
          ctl.pop = 1'b1;
          if (discard_q || stat.len_zero) begin
            want_res = 1'b1;
          end else begin
            state_next = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        if (consume) begin
          ctl.out_load   = 1'b1;
          ctl.out_stream = 1'b1;
          ctl.out_last   = pend_last;
          ctl.out_status = ST_NORMAL;
          if (pend_last) begin
            state_next = S_IDLE;
          end
        end
        if (stat.issue_more && (!pend || consume)) begin
          ctl.byte_rd = 1'b1;
        end
      end
      S_EMIT: begin
        want_res = 1'b1;
        res_code = emit_code;
      end
      default: state_next = S_IDLE;
    endcase
    if (want_res) begin
      if (slot_free) begin
        ctl.out_load   = 1'b1;
        ctl.out_status = res_code;
        state_next     = S_IDLE;
      end else begin
        emit_code_next = res_code;
        state_next     = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      emit_code <= ST_NORMAL;
      discard_q <= 1'b0;
    end else begin
      state     <= state_next;
      emit_code <= emit_code_next;
      if (ctl.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cmd_valid && cmd_ready) begin
        discard_q <= discard_frame;
      end
      if (ctl.byte_rd) begin
        pend      <= 1'b1;
        pend_last <= stat.issue_last;
      end else if (consume) begin
        pend <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!res_valid || res_ready))
    else $error("output register loaded while a word was still waiting");

  a_stream_ends: assert property (@(posedge clk) disable iff (rst)
    (consume && pend_last) |=> (state == S_IDLE))
    else $error("stream did not end after its last byte");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.byte_rd |-> (stat.issue_more && (state == S_STREAM)))
    else $error("byte read issued past the frame length");

  a_meta_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.meta_rd |-> !stat.empty)
    else $error("slot lookup on an empty ring");

endmodule

/* rtl/overwriting_frame_ring_queue.sv */
// Push, flush, status and empty-pull words: result loaded at the accepting edge if the output
// register is free, else once it frees up; one per cycle while it stays free. Pull of an L-byte
// frame: slot lookup, the byte store's registered read, then one byte per cycle while it is free;
// no new command before its last byte. Oversize and discard pulls load at lookup or once free.
// Reset (synchronous, active high) clears the ring pointers, the frame being built and the
// handshake state; the byte store and slot lengths keep their contents.
module overwriting_frame_ring_queue import ofrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  ofrq_cmd_if.sink   cmd,
  ofrq_res_if.source result
);

  // The controller decides, cycle by cycle, what the datapath does: commit a
  // pushed byte, flush the ring, look up the oldest slot, free it, fetch a stored
  // byte, or load the output register. The datapath answers with a small status bundle.
  ofrq_ctl_t  ctl;
  ofrq_stat_t stat;

  // Controller: holds the state machine, the output register's valid flag and
  // the single-entry read pipeline flag used while a frame streams out. A new
  // command word is taken whenever the controller is idle, even while the
  // previous result word still sits in the output register; its result then
  // waits in the controller until the register frees up.
  ofrq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .command       (cmd.command),
    .discard_frame (cmd.discard_frame),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .stat          (stat),
    .ctl           (ctl)
  );

  // Datapath: the head and tail pointers of the ring, the byte store of
  // QUEUE_DEPTH slots of FRAME_BYTES bytes each, the per-slot length and
  // oversize mark, and the output register. Every result word carries the
  // frame count and the empty and full flags as they stand after its command.
  ofrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .data_byte   (cmd.data_byte),
    .last_byte   (cmd.last_byte),
    .stat        (stat),
    .status_code (result.status_code),
    .byte_valid  (result.byte_valid),
    .out_byte    (result.out_byte),
    .out_last    (result.out_last),
    .frame_count (result.frame_count),
    .queue_empty (result.queue_empty),
    .queue_full  (result.queue_full)
  );

endmodule
